// ===== rtl/fvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types and constants of the fluctuation vertex pipeline.
// ----------------------------------------------------------------------------
package fvc_pkg;

   // Fraction bits of the internal z, z^2, N and D values.
   localparam int WORK_BITS = 28;

   // Quotient bits resolved by the divider, one per pipeline stage.
   localparam int DIV_STEPS = 32;
   localparam int QUO_W     = DIV_STEPS;
   localparam int Q_W       = 64;
   localparam int NUM_W     = Q_W + QUO_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONSITE_U     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPLEX_MODE = 1'd1;

   // Result of one divider lane: overflow, sign and quotient magnitude.
   typedef struct packed {
      logic             big;
      logic             neg;
      logic [QUO_W-1:0] quo;
   } fvc_quot_type;

endpackage

// ===== rtl/fvc_divider.sv =====
// ----------------------------------------------------------------------------
// fvc_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module fvc_divider (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [fvc_pkg::NUM_W-1:0] num_in,
   input  logic [fvc_pkg::Q_W-1:0]   q_in,
   input  logic                     neg_in,
   output fvc_pkg::fvc_quot_type     res
);
   import fvc_pkg::*;

   logic [Q_W-1:0]   rem_ff [DIV_STEPS];
   logic [QUO_W-1:0] low_ff [DIV_STEPS];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS];
   logic [Q_W-1:0]   q_ff   [DIV_STEPS];
   logic             neg_ff [DIV_STEPS];
   logic             big_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [Q_W-1:0]   rem_p;
      logic [QUO_W-1:0] low_p;
      logic [QUO_W-1:0] quo_p;
      logic [Q_W-1:0]   q_p;
      logic             neg_p;
      logic             big_p;
      logic [Q_W-1:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         // A high half at or above q means the quotient needs more than QUO_W bits.
         always_comb begin
            rem_p = num_in[NUM_W-1:QUO_W];
            low_p = num_in[QUO_W-1:0];
            quo_p = '0;
            q_p   = q_in;
            neg_p = neg_in;
            big_p = (num_in[NUM_W-1:QUO_W] >= q_in);
         end
      end else begin : g_next
         always_comb begin
            rem_p = rem_ff[k-1];
            low_p = low_ff[k-1];
            quo_p = quo_ff[k-1];
            q_p   = q_ff[k-1];
            neg_p = neg_ff[k-1];
            big_p = big_ff[k-1];
         end
      end

      assign trial = {rem_p[Q_W-2:0], low_p[QUO_W-1]};
      assign take  = (trial >= q_p);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= take ? (trial - q_p) : trial;
            low_ff[k] <= {low_p[QUO_W-2:0], 1'b0};
            quo_ff[k] <= {quo_p[QUO_W-2:0], take};
            q_ff[k]   <= q_p;
            neg_ff[k] <= neg_p;
            big_ff[k] <= big_p;
         end
      end
   end

   assign res.big = big_ff[DIV_STEPS-1];
   assign res.neg = neg_ff[DIV_STEPS-1];
   assign res.quo = quo_ff[DIV_STEPS-1];

endmodule

// ===== rtl/fluctuation_vertex_complex.sv =====
// ----------------------------------------------------------------------------
// fluctuation_vertex_complex
// RPA effective interaction vertex V = U (z + 2 z^2) / (1 - z^2), z = U X.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the req_ channel carries one susceptibility sample
// (chi_real, chi_imag) in signed fixed point. Each one yields exactly one
// rsp_ transaction with the vertex parts and the diverged and saturated flags.
// The csr_ port writes U and the complex mode bit; write it only while no
// transaction is in flight.
// The block is a 42-stage pipeline: nine arithmetic stages, a 32-stage
// divider that resolves one quotient bit per stage, and the output register.
// One transaction is taken every cycle while the output is not stalled.
// When rsp_stall is high while a result is presented, the whole pipeline
// holds and req_stall rises in the same cycle; nothing is dropped.
// Reset clears all valid bits, sets U to zero and selects complex mode.
// ----------------------------------------------------------------------------
module fluctuation_vertex_complex #(
   parameter int FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_chi_real,
   input  logic signed [31:0]                req_chi_imag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_vertex_real,
   output logic signed [31:0]                rsp_vertex_imag,
   output logic                              rsp_diverged,
   output logic                              rsp_saturated,
   input  logic                              csr_write,
   input  logic [fvc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fvc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fvc_pkg::*;

   localparam int SHIFT  = 2 * FRAC_BITS - WORK_BITS;
   localparam int THRESH = 4 * FRAC_BITS;
   localparam int PRE    = 9;

   function automatic logic signed [31:0] round_work(input logic signed [61:0] v);
      logic signed [61:0] t;
      begin
         t = v + (62'sd1 <<< (WORK_BITS - 1));
         return 32'(t >>> WORK_BITS);
      end
   endfunction

   // Returns {saturated, value}. An overflowing quotient clamps toward its sign.
   function automatic logic [32:0] finish_part(input fvc_quot_type p);
      logic negative;
      begin
         negative = p.neg & (p.big | (p.quo != '0));
         if (!negative && (p.big || p.quo > 32'h7FFF_FFFF))
            return {1'b1, 32'h7FFF_FFFF};
         else if (negative && (p.big || p.quo > 32'h8000_0000))
            return {1'b1, 32'h8000_0000};
         else if (negative)
            return {1'b0, 32'(~p.quo + 32'd1)};
         else
            return {1'b0, 32'(p.quo)};
      end
   endfunction

   logic signed [31:0] onsite_u_ff;
   logic               complex_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         onsite_u_ff     <= '0;
         complex_mode_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ONSITE_U:     onsite_u_ff     <= signed'(csr_wdata[31:0]);
            CSR_COMPLEX_MODE: complex_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [PRE-1:0]       pre_vld_ff;
   logic [DIV_STEPS-1:0] dv_vld_ff;
   logic [DIV_STEPS-1:0] dv_div_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Magnitudes used by the exact divergence test and the final scaling.
   logic [31:0] u_bits, u_mag, xr_bits, xr_mag, xi_bits, xi_mag;
   logic signed [31:0] xi_eff;

   assign xi_eff  = complex_mode_ff ? req_chi_imag : '0;
   assign u_bits  = onsite_u_ff;
   assign xr_bits = req_chi_real;
   assign xi_bits = xi_eff;
   assign u_mag   = u_bits[31]  ? (~u_bits + 32'd1)  : u_bits;
   assign xr_mag  = xr_bits[31] ? (~xr_bits + 32'd1) : xr_bits;
   assign xi_mag  = xi_bits[31] ? (~xi_bits + 32'd1) : xi_bits;

   // Stage 1: U X products and squared magnitudes.
   logic signed [63:0] s1_ur_ff, s1_ui_ff;
   logic [63:0]        s1_uu_ff, s1_xr2_ff, s1_xi2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ur_ff  <= 64'(onsite_u_ff) * 64'(req_chi_real);
         s1_ui_ff  <= 64'(onsite_u_ff) * 64'(xi_eff);
         s1_uu_ff  <= 64'(u_mag) * 64'(u_mag);
         s1_xr2_ff <= 64'(xr_mag) * 64'(xr_mag);
         s1_xi2_ff <= 64'(xi_mag) * 64'(xi_mag);
      end
   end

   // Stage 2: z rounded to the working precision; |X|^2.
   logic signed [29:0] zr_in, zi_in;
   logic signed [29:0] s2_zr_ff, s2_zi_ff;
   logic [63:0]        s2_uu_ff, s2_msq_ff;

   if (SHIFT > 0) begin : g_shr
      logic signed [63:0] tr, ti;
      assign tr    = (s1_ur_ff + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
      assign ti    = (s1_ui_ff + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
      assign zr_in = tr[29:0];
      assign zi_in = ti[29:0];
   end else if (SHIFT < 0) begin : g_shl
      logic signed [63:0] tr, ti;
      assign tr    = s1_ur_ff <<< (-SHIFT);
      assign ti    = s1_ui_ff <<< (-SHIFT);
      assign zr_in = tr[29:0];
      assign zi_in = ti[29:0];
   end else begin : g_same
      assign zr_in = s1_ur_ff[29:0];
      assign zi_in = s1_ui_ff[29:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_zr_ff  <= zr_in;
         s2_zi_ff  <= zi_in;
         s2_uu_ff  <= s1_uu_ff;
         s2_msq_ff <= s1_xr2_ff + s1_xi2_ff;
      end
   end

   // Stage 3: partial products of U^2 |X|^2 and the products for z^2.
   logic [63:0]        s3_pp00_ff, s3_pp01_ff, s3_pp10_ff, s3_pp11_ff;
   logic signed [59:0] s3_rr_ff, s3_ii_ff, s3_ri_ff;
   logic signed [29:0] s3_zr_ff, s3_zi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_pp00_ff <= 64'(s2_uu_ff[31:0])  * 64'(s2_msq_ff[31:0]);
         s3_pp01_ff <= 64'(s2_uu_ff[31:0])  * 64'(s2_msq_ff[63:32]);
         s3_pp10_ff <= 64'(s2_uu_ff[63:32]) * 64'(s2_msq_ff[31:0]);
         s3_pp11_ff <= 64'(s2_uu_ff[63:32]) * 64'(s2_msq_ff[63:32]);
         s3_rr_ff   <= 60'(s2_zr_ff) * 60'(s2_zr_ff);
         s3_ii_ff   <= 60'(s2_zi_ff) * 60'(s2_zi_ff);
         s3_ri_ff   <= 60'(s2_zr_ff) * 60'(s2_zi_ff);
         s3_zr_ff   <= s2_zr_ff;
         s3_zi_ff   <= s2_zi_ff;
      end
   end

   // Stage 4: exact |U X| >= 1 test and z^2.
   logic [127:0]       prod_in;
   logic               s4_div_ff;
   logic signed [31:0] s4_z2r_ff, s4_z2i_ff;
   logic signed [29:0] s4_zr_ff, s4_zi_ff;

   assign prod_in = (128'(s3_pp11_ff) << 64) + (128'(s3_pp10_ff) << 32)
                  + (128'(s3_pp01_ff) << 32) + 128'(s3_pp00_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_div_ff <= ((prod_in >> THRESH) != '0);
         s4_z2r_ff <= round_work(62'(s3_rr_ff) - 62'(s3_ii_ff));
         s4_z2i_ff <= round_work(62'(s3_ri_ff) <<< 1);
         s4_zr_ff  <= s3_zr_ff;
         s4_zi_ff  <= s3_zi_ff;
      end
   end

   // Stage 5: N = z + 2 z^2 and D = 1 - z^2.
   logic signed [31:0] s5_nr_ff, s5_ni_ff, s5_dr_ff, s5_di_ff;
   logic               s5_div_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_nr_ff  <= 32'(s4_zr_ff) + (s4_z2r_ff <<< 1);
         s5_ni_ff  <= 32'(s4_zi_ff) + (s4_z2i_ff <<< 1);
         s5_dr_ff  <= (32'sd1 <<< WORK_BITS) - s4_z2r_ff;
         s5_di_ff  <= -s4_z2i_ff;
         s5_div_ff <= s4_div_ff;
      end
   end

   // Stage 6: products for |D|^2 and N conj(D).
   logic signed [63:0] s6_drr_ff, s6_dii_ff, s6_nrr_ff, s6_nii_ff, s6_nir_ff, s6_nri_ff;
   logic               s6_div_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_drr_ff <= 64'(s5_dr_ff) * 64'(s5_dr_ff);
         s6_dii_ff <= 64'(s5_di_ff) * 64'(s5_di_ff);
         s6_nrr_ff <= 64'(s5_nr_ff) * 64'(s5_dr_ff);
         s6_nii_ff <= 64'(s5_ni_ff) * 64'(s5_di_ff);
         s6_nir_ff <= 64'(s5_ni_ff) * 64'(s5_dr_ff);
         s6_nri_ff <= 64'(s5_nr_ff) * 64'(s5_di_ff);
         s6_div_ff <= s5_div_ff;
      end
   end

   // Stage 7: q = |D|^2 and the two numerator parts.
   logic [63:0]        q_in;
   logic [63:0]        s7_q_ff;
   logic signed [63:0] s7_pr_ff, s7_pi_ff;
   logic               s7_div_ff;

   assign q_in = s6_drr_ff + s6_dii_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_q_ff   <= q_in;
         s7_pr_ff  <= s6_nrr_ff + s6_nii_ff;
         s7_pi_ff  <= s6_nir_ff - s6_nri_ff;
         // A vanishing denominator counts as divergence.
         s7_div_ff <= s6_div_ff | (q_in == '0);
      end
   end

   // Stage 8: |U| |P| as two partial products per part.
   logic [63:0] pr_bits, pi_bits, pr_mag, pi_mag;
   logic [62:0] s8_phr_ff, s8_phi_ff;
   logic [63:0] s8_plr_ff, s8_pli_ff, s8_q_ff;
   logic        s8_negr_ff, s8_negi_ff, s8_div_ff;

   assign pr_bits = s7_pr_ff;
   assign pi_bits = s7_pi_ff;
   assign pr_mag  = pr_bits[63] ? (~pr_bits + 64'd1) : pr_bits;
   assign pi_mag  = pi_bits[63] ? (~pi_bits + 64'd1) : pi_bits;

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_phr_ff  <= 63'(64'(u_mag) * 64'(pr_mag[62:32]));
         s8_phi_ff  <= 63'(64'(u_mag) * 64'(pi_mag[62:32]));
         s8_plr_ff  <= 64'(u_mag) * 64'(pr_mag[31:0]);
         s8_pli_ff  <= 64'(u_mag) * 64'(pi_mag[31:0]);
         s8_negr_ff <= u_bits[31] ^ pr_bits[63];
         s8_negi_ff <= u_bits[31] ^ pi_bits[63];
         s8_q_ff    <= s7_q_ff;
         s8_div_ff  <= s7_div_ff;
      end
   end

   // Stage 9: dividends with the rounding half of q added.
   logic [NUM_W-1:0] s9_numr_ff, s9_numi_ff;
   logic [Q_W-1:0]   s9_q_ff;
   logic             s9_negr_ff, s9_negi_ff, s9_div_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_numr_ff <= (NUM_W'(s8_phr_ff) << 32) + NUM_W'(s8_plr_ff) + NUM_W'(s8_q_ff >> 1);
         s9_numi_ff <= (NUM_W'(s8_phi_ff) << 32) + NUM_W'(s8_pli_ff) + NUM_W'(s8_q_ff >> 1);
         s9_q_ff    <= s8_q_ff;
         s9_negr_ff <= s8_negr_ff;
         s9_negi_ff <= s8_negi_ff;
         s9_div_ff  <= s8_div_ff;
      end
   end

   fvc_quot_type quo_r, quo_i;

   fvc_divider u_div_real (
      .clock  (clock),
      .adv    (adv),
      .num_in (s9_numr_ff),
      .q_in   (s9_q_ff),
      .neg_in (s9_negr_ff),
      .res    (quo_r)
   );

   fvc_divider u_div_imag (
      .clock  (clock),
      .adv    (adv),
      .num_in (s9_numi_ff),
      .q_in   (s9_q_ff),
      .neg_in (s9_negi_ff),
      .res    (quo_i)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
         dv_vld_ff  <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[PRE-2:0], req_valid};
         dv_vld_ff  <= {dv_vld_ff[DIV_STEPS-2:0], pre_vld_ff[PRE-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_div_ff <= {dv_div_ff[DIV_STEPS-2:0], s9_div_ff};
      end
   end

   // Output register.
   logic [32:0]        fin_r, fin_i;
   logic signed [31:0] out_real_ff, out_imag_ff;
   logic               out_div_ff, out_sat_ff;

   assign fin_r = finish_part(quo_r);
   assign fin_i = finish_part(quo_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (dv_div_ff[DIV_STEPS-1]) begin
            out_real_ff <= '0;
            out_imag_ff <= '0;
            out_div_ff  <= 1'b1;
            out_sat_ff  <= 1'b0;
         end else begin
            out_real_ff <= signed'(fin_r[31:0]);
            out_imag_ff <= signed'(fin_i[31:0]);
            out_div_ff  <= 1'b0;
            out_sat_ff  <= fin_r[32] | fin_i[32];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_real = out_real_ff;
   assign rsp_vertex_imag = out_imag_ff;
   assign rsp_diverged    = out_div_ff;
   assign rsp_saturated   = out_sat_ff;

`ifndef SYNTHESIS
   a_diverged_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_diverged |->
         rsp_vertex_real == '0 && rsp_vertex_imag == '0 && !rsp_saturated)
      else $error("diverged transaction carries a nonzero vertex or saturation");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result presented right after reset");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while the output is stalled");
`endif

endmodule

// ===== tb/fluctuation_vertex_complex_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fluctuation_vertex_complex_check
// Watches the request, response and register ports of the vertex block,
// predicts each response from the accepted sample and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module fluctuation_vertex_complex_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [31:0]                req_chi_real,
   input  logic signed [31:0]                req_chi_imag,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [31:0]                rsp_vertex_real,
   input  logic signed [31:0]                rsp_vertex_imag,
   input  logic                              rsp_diverged,
   input  logic                              rsp_saturated,
   input  logic                              csr_write,
   input  logic [fvc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fvc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);
   import fvc_pkg::*;

   localparam int FRAC = 24;
   localparam int WORK = 28;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               dv;
      logic               st;
   } vertex_type;

   logic signed [31:0] u_reg;
   logic               cplx_reg;
   vertex_type         pending_vertices[$];

   function automatic logic [63:0] mag(longint v);
      return 64'(v < 0 ? -v : v);
   endfunction

   // Round to nearest at the given shift, ties toward plus infinity.
   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // One vertex part: |u| |p| / q rounded half away from zero, clamped.
   // Bit 32 of the return value flags a clamp.
   function automatic logic [32:0] vertex_part(longint u, longint p, logic [63:0] q);
      logic [129:0] num;
      logic [129:0] quo;
      logic         neg;
      num = 130'(mag(u)) * 130'(mag(p)) + 130'(q >> 1);
      quo = num / 130'(q);
      neg = (u < 0) != (p < 0);
      if (quo == 0)
         neg = 1'b0;
      if (!neg && quo > 130'h7FFF_FFFF)
         return {1'b1, 32'h7FFF_FFFF};
      if (neg && quo > 130'h8000_0000)
         return {1'b1, 32'h8000_0000};
      if (neg)
         return {1'b0, -quo[31:0]};
      return {1'b0, quo[31:0]};
   endfunction

   function automatic vertex_type predict_vertex(logic signed [31:0] cr, logic signed [31:0] ci);
      vertex_type  v;
      longint      u, xr, xi, zr, zi, z2r, z2i, nr, ni, dr, di, pr, pim;
      logic [63:0] uu, xx, q;
      logic [127:0] prod;
      logic [32:0] part_re, part_im;
      v  = '0;
      u  = longint'(u_reg);
      xr = longint'(cr);
      xi = cplx_reg ? longint'(ci) : 64'sd0;
      uu = mag(u) * mag(u);
      xx = mag(xr) * mag(xr) + mag(xi) * mag(xi);
      prod = 128'(uu) * 128'(xx);
      if (prod >= (128'd1 << (4 * FRAC))) begin
         v.dv = 1'b1;
         return v;
      end
      zr  = round_shift(u * xr, 2 * FRAC - WORK);
      zi  = round_shift(u * xi, 2 * FRAC - WORK);
      z2r = round_shift(zr * zr - zi * zi, WORK);
      z2i = round_shift(2 * zr * zi, WORK);
      nr  = zr + 2 * z2r;
      ni  = zi + 2 * z2i;
      dr  = (64'sd1 <<< WORK) - z2r;
      di  = -z2i;
      q   = 64'(dr * dr) + 64'(di * di);
      if (q == 0) begin
         v.dv = 1'b1;
         return v;
      end
      pr  = nr * dr + ni * di;
      pim = ni * dr - nr * di;
      part_re = vertex_part(u, pr, q);
      part_im = cplx_reg ? vertex_part(u, pim, q) : 33'd0;
      v.re = part_re[31:0];
      v.im = part_im[31:0];
      v.st = part_re[32] | part_im[32];
      return v;
   endfunction

   assign outstanding = pending_vertices.size();

   // Sampling at the falling edge sees values that hold through the next
   // rising edge, where the transactions actually take place.
   always @(negedge clock) begin
      vertex_type want, got;
      if (reset) begin
         u_reg    <= '0;
         cplx_reg <= 1'b1;
         pending_vertices.delete();
         mismatches <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ONSITE_U:     u_reg    <= csr_wdata;
               CSR_COMPLEX_MODE: cplx_reg <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_vertices.insert(pending_vertices.size(),
                                    predict_vertex(req_chi_real, req_chi_imag));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_vertex_real, rsp_vertex_imag, rsp_diverged, rsp_saturated};
            if (pending_vertices.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response %h %h dv=%b st=%b",
                           got.re, got.im, got.dv, got.st);
               mismatches <= mismatches + 1;
            end else begin
               want = pending_vertices.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("mismatch: expected %h %h dv=%b st=%b, got %h %h dv=%b st=%b",
                              want.re, want.im, want.dv, want.st,
                              got.re, got.im, got.dv, got.st);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/fluctuation_vertex_complex_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fluctuation_vertex_complex_test
// Drives directed and random susceptibility samples through the vertex block
// under several U and mode settings, with random gaps and response stalls.
// ----------------------------------------------------------------------------
module fluctuation_vertex_complex_test;
   import fvc_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [31:0] ONE = 32'sd16777216;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [31:0]         req_chi_real = '0;
   logic signed [31:0]         req_chi_imag = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [31:0]         rsp_vertex_real;
   logic signed [31:0]         rsp_vertex_imag;
   logic                       rsp_diverged;
   logic                       rsp_saturated;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   int                         mismatches;
   int                         outstanding;
   logic                       gaps_on = 1'b1;
   logic                       stalls_on = 1'b1;
   int                         stall_left = 0;

   always #2 clock = ~clock;

   fluctuation_vertex_complex dut (.*);

   fluctuation_vertex_complex_check checker_inst (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response stalls come in runs of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(logic signed [31:0] cr, logic signed [31:0] ci);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_chi_real <= cr;
      req_chi_imag <= ci;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // Registers are only touched once the pipeline has drained.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_chi();
      return $signed($urandom) >>> $urandom_range(0, 31);
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_sample(rand_chi(), rand_chi());
   endtask

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [31:0] u_set[8];
      u_set = '{ONE, -ONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0080_0000,
                32'h0000_0001, 32'h0340_0000, 32'hFF10_0000};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // U is zero out of reset.
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
      write_reg(CSR_ONSITE_U, ONE);
      gaps_on = 1'b0;
      send_sample(0, 0);
      send_sample(32'sh0080_0000, 0);
      send_sample(-32'sh0080_0000, 0);
      send_sample(ONE, 0);
      send_sample(-ONE, 0);
      send_sample(0, ONE);
      send_sample(0, 32'sh00C0_0000);
      send_sample(ONE - 1, 0);
      send_sample(-ONE + 1, 0);
      send_sample(32'sh00B5_04F3, 32'sh00B5_04F3);
      send_sample(32'sh00B5_04F2, 32'sh00B5_04F2);
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000, 32'sh8000_0000);
      send_sample(32'sh0000_0001, -32'sh0000_0001);
      gaps_on = 1'b1;
      write_reg(CSR_COMPLEX_MODE, 32'd0);
      send_sample(ONE - 1, 32'sh7FFF_FFFF);
      send_sample(32'sh0080_0000, -32'sh8000_0000);
      send_sample(ONE, ONE);
      send_sample(-32'sh00FF_FFF0, 32'sh1234_5678);
      random_phase(100);
      write_reg(CSR_COMPLEX_MODE, 32'd1);

      for (int k = 0; k < 8; k++) begin
         write_reg(CSR_ONSITE_U, u_set[k]);
         if (k == 3) write_reg(CSR_COMPLEX_MODE, 32'd0);
         if (k == 5) write_reg(CSR_COMPLEX_MODE, 32'd1);
         gaps_on   = (k % 3) != 1;
         stalls_on = (k % 4) != 2;
         random_phase(130);
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      for (int k = 0; k < 6; k++) begin
         write_reg(CSR_ONSITE_U, $urandom);
         write_reg(CSR_COMPLEX_MODE, $urandom_range(0, 1));
         random_phase(80);
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/fvc_pkg.sv
rtl/fvc_divider.sv
rtl/fluctuation_vertex_complex.sv
tb/fluctuation_vertex_complex_check.sv
tb/fluctuation_vertex_complex_test.sv
